// ===== design/brs_pkg.sv =====
// brs_pkg: field widths, register indexes and item codes of the bilinear RGB scaler.
// No dependencies; imported by the scaler top level and its port checker.
`timescale 1ns / 1ps

package brs_pkg;

  // fixed field widths
  localparam int SW_W       = 9;   // source width register
  localparam int SH_W       = 9;   // source height register
  localparam int TW_W       = 11;  // target width register
  localparam int TH_W       = 10;  // target height register
  localparam int COORD_W    = 10;  // x_pos / y_pos
  localparam int CH_W       = 8;   // one colour channel
  localparam int PIX_W      = 3 * CH_W;

  // fixed point
  localparam int FRAC_W     = 16;               // Q16 step
  localparam int WFRAC_W    = 8;                // weight bits below the integer part
  localparam int STEP_W     = SW_W + FRAC_W;    // ((w-1) << 16) / w' fits here
  localparam int PROD_W     = COORD_W + STEP_W; // coord * step
  localparam int WT_W       = WFRAC_W + 1;      // 0..256
  localparam int NWT_W      = 2 * WT_W - 1;     // 0..65536
  localparam int ACC_W      = CH_W + 2 * WFRAC_W;

  localparam logic [WT_W-1:0] WT_ONE = WT_W'(1 << WFRAC_W);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_HEIGHT = 3'd3;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef logic [STEP_W-1:0] step_t;
  typedef logic [PIX_W-1:0]  pixel_t;

endpackage

// ===== design/bilinear_rgb_scaler.sv =====
// bilinear_rgb_scaler: top level. Source pixel store, Q16 step divider, sample sequencer.
// Depends on brs_pkg, brs_ram and brs_div.
`timescale 1ns / 1ps

// Channel   | Handshake                 | Payload
// ----------+---------------------------+---------------------------------------------
// item in   | start, busy (beat on      | kind, x_pos, y_pos, pixel_red/green/blue
//           |   start & !busy)          |
// result    | done (one-cycle strobe)   | red, green, blue, out_of_range
// config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//           |   ready low on busy|start |
//
// Sequencing: a load beat leaves busy low. An out-of-range sample gives its result in the
// next cycle with busy low. An in-range sample keeps busy high through two passes of the
// coordinate * step multiplier, four reads of the single-port pixel store and one
// accumulate drain; its strobe comes with busy already low.
// Reset and every accepted config beat to a known register start a step recompute: two
// serial divisions, busy high throughout. Reset is synchronous.
// The result side cannot stall; the strobe lasts exactly one cycle.

module bilinear_rgb_scaler #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_WIDTH  = 1024,
  parameter int MAX_DST_HEIGHT = 600
) (
  input  logic                            clk,
  input  logic                            rst,
  // item in
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind,
  input  logic [brs_pkg::COORD_W-1:0]     x_pos,
  input  logic [brs_pkg::COORD_W-1:0]     y_pos,
  input  logic [brs_pkg::CH_W-1:0]        pixel_red,
  input  logic [brs_pkg::CH_W-1:0]        pixel_green,
  input  logic [brs_pkg::CH_W-1:0]        pixel_blue,
  // result
  output logic                            done,
  output logic [brs_pkg::CH_W-1:0]        red,
  output logic [brs_pkg::CH_W-1:0]        green,
  output logic [brs_pkg::CH_W-1:0]        blue,
  output logic                            out_of_range,
  // config
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [brs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import brs_pkg::*;

  // store addressing: {row, col}, row stride a power of two
  localparam int CW    = $clog2(MAX_SRC_WIDTH);
  localparam int RW    = $clog2(MAX_SRC_HEIGHT);
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;

  localparam int SW_RST = (MAX_SRC_WIDTH  < 256)  ? MAX_SRC_WIDTH  : 256;
  localparam int SH_RST = (MAX_SRC_HEIGHT < 256)  ? MAX_SRC_HEIGHT : 256;
  localparam int TW_RST = (MAX_DST_WIDTH  < 1024) ? MAX_DST_WIDTH  : 1024;
  localparam int TH_RST = (MAX_DST_HEIGHT < 600)  ? MAX_DST_HEIGHT : 600;

  // sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DXS  = 4'd1;  // launch x step division
  localparam logic [3:0] ST_DXW  = 4'd2;
  localparam logic [3:0] ST_DYS  = 4'd3;  // launch y step division
  localparam logic [3:0] ST_DYW  = 4'd4;
  localparam logic [3:0] ST_MX   = 4'd5;  // x position
  localparam logic [3:0] ST_MY   = 4'd6;  // y position
  localparam logic [3:0] ST_RD   = 4'd7;  // neighbour reads
  localparam logic [3:0] ST_FIN  = 4'd8;  // last accumulate, result out

  // zero reads as one, above the maximum reads as the maximum
  function automatic logic [CFG_DATA_W-1:0] clamp_cfg(input logic [CFG_DATA_W-1:0] v,
                                                      input int unsigned hi);
    logic [CFG_DATA_W-1:0] r;
    if (v == '0) begin
      r = CFG_DATA_W'(1);
    end else if (32'(v) > hi) begin
      r = CFG_DATA_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [3:0]         state, state_next;
  logic [SW_W-1:0]    img_width;
  logic [SH_W-1:0]    img_height;
  logic [TW_W-1:0]    tgt_width;
  logic [TH_W-1:0]    tgt_height;
  step_t              x_step, y_step;

  logic               accept, cfg_we, cfg_known;
  logic               load_ok, smp, smp_oor;

  logic [COORD_W-1:0] x_c, y_c;
  logic [SW_W-1:0]    x1, x2;
  logic [SH_W-1:0]    y1, y2;
  logic [WFRAC_W-1:0] wx, wy;
  logic [1:0]         nb_k;
  logic [SW_W-1:0]    nb_col;
  logic [SH_W-1:0]    nb_row;
  logic [WT_W-1:0]    fx, fy;
  logic [NWT_W-1:0]   wt;
  logic               acc_en;

  logic [COORD_W-1:0] mul_a;
  step_t              mul_b;
  logic [PROD_W-1:0]  prod;

  logic [ACC_W-1:0]   acc_r, acc_g, acc_b;
  logic [ACC_W-1:0]   sum_r, sum_g, sum_b;

  logic               div_start, div_done;
  step_t              div_num, div_quot;
  logic [TW_W-1:0]    div_den;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  pixel_t             ram_wdata, ram_rdata;

  // ---------------------------------------------------------------- handshakes
  always_comb begin
    busy      = (state != ST_IDLE);
    // an item on offer keeps the register port shut, so the two never share an edge
    cfg_ready = !busy && !start;
    accept    = start && !busy;
    cfg_we    = cfg_valid && cfg_ready;
    cfg_known = (cfg_index == REG_SRC_WIDTH)  || (cfg_index == REG_SRC_HEIGHT) ||
                (cfg_index == REG_TGT_WIDTH)  || (cfg_index == REG_TGT_HEIGHT);
    // a load outside the source image is dropped
    load_ok   = accept && (kind == KIND_LOAD) &&
                (x_pos < COORD_W'(img_width)) && (y_pos < COORD_W'(img_height));
    smp       = accept && (kind == KIND_SAMPLE);
    smp_oor   = ({1'b0, x_pos} >= tgt_width) || (y_pos >= tgt_height);
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cfg_we && cfg_known) begin
          state_next = ST_DXS;
        end else if (smp && !smp_oor) begin
          state_next = ST_MX;
        end
      end
      ST_DXS:  state_next = ST_DXW;
      ST_DXW:  state_next = div_done ? ST_DYS : ST_DXW;
      ST_DYS:  state_next = ST_DYW;
      ST_DYW:  state_next = div_done ? ST_IDLE : ST_DYW;
      ST_MX:   state_next = ST_MY;
      ST_MY:   state_next = ST_RD;
      ST_RD:   state_next = (nb_k == 2'd3) ? ST_FIN : ST_RD;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_DXS;
      done   <= 1'b0;
      acc_en <= 1'b0;
    end else begin
      state  <= state_next;
      done   <= (state == ST_FIN) || (smp && smp_oor);
      acc_en <= (state == ST_RD);
    end
  end

  // ---------------------------------------------------------------- config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= SW_W'(SW_RST);
      img_height <= SH_W'(SH_RST);
      tgt_width  <= TW_W'(TW_RST);
      tgt_height <= TH_W'(TH_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:
          img_width  <= SW_W'(clamp_cfg(CFG_DATA_W'(cfg_data[SW_W-1:0]), MAX_SRC_WIDTH));
        REG_SRC_HEIGHT:
          img_height <= SH_W'(clamp_cfg(CFG_DATA_W'(cfg_data[SH_W-1:0]), MAX_SRC_HEIGHT));
        REG_TGT_WIDTH:
          tgt_width  <= TW_W'(clamp_cfg(CFG_DATA_W'(cfg_data[TW_W-1:0]), MAX_DST_WIDTH));
        REG_TGT_HEIGHT:
          tgt_height <= TH_W'(clamp_cfg(CFG_DATA_W'(cfg_data[TH_W-1:0]), MAX_DST_HEIGHT));
        default: ;  // unknown index: no effect
      endcase
    end
  end

  // ---------------------------------------------------------------- step divider
  // step = ((size - 1) << 16) / target, recomputed after reset and each known-register write
  always_comb begin
    div_start = (state == ST_DXS) || (state == ST_DYS);
    if (state == ST_DXS) begin
      div_num = {SW_W'(img_width - 1'b1), FRAC_W'(0)};
      div_den = tgt_width;
    end else begin
      div_num = {SH_W'(img_height - 1'b1), FRAC_W'(0)};
      div_den = TW_W'(tgt_height);
    end
  end

  brs_div #(
    .NUM_W (STEP_W),
    .DEN_W (TW_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (state == ST_DXW && div_done) begin
      x_step <= div_quot;
    end
    if (state == ST_DYW && div_done) begin
      y_step <= div_quot;
    end
  end

  // ---------------------------------------------------------------- position multiplier
  // one multiplier, x pass then y pass
  always_comb begin
    mul_a = (state == ST_MX) ? x_c : y_c;
    mul_b = (state == ST_MX) ? x_step : y_step;
    prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // neighbour k: bit 0 picks right column, bit 1 picks lower row
  always_comb begin
    x2     = (x1 < SW_W'(img_width - 1'b1))  ? SW_W'(x1 + 1'b1) : x1;
    y2     = (y1 < SH_W'(img_height - 1'b1)) ? SH_W'(y1 + 1'b1) : y1;
    nb_col = nb_k[0] ? x2 : x1;
    nb_row = nb_k[1] ? y2 : y1;
    fx     = nb_k[0] ? WT_W'(wx) : WT_ONE - WT_W'(wx);
    fy     = nb_k[1] ? WT_W'(wy) : WT_ONE - WT_W'(wy);
  end

  always_ff @(posedge clk) begin
    if (smp) begin
      x_c <= x_pos;
      y_c <= y_pos;
    end
    if (state == ST_MX) begin
      // x1 < source width, so the integer part fits the register width
      x1 <= prod[FRAC_W +: SW_W];
      wx <= prod[FRAC_W-WFRAC_W +: WFRAC_W];
    end
    if (state == ST_MY) begin
      y1   <= prod[FRAC_W +: SH_W];
      wy   <= prod[FRAC_W-WFRAC_W +: WFRAC_W];
      nb_k <= 2'd0;
    end
    if (state == ST_RD) begin
      nb_k <= nb_k + 1'b1;
      wt   <= NWT_W'(fx * fy);   // lines up with the registered read data
    end
  end

  // ---------------------------------------------------------------- pixel store
  always_comb begin
    ram_we    = load_ok;
    ram_addr  = load_ok ? {RW'(y_pos), CW'(x_pos)} : {RW'(nb_row), CW'(nb_col)};
    ram_wdata = {pixel_red, pixel_green, pixel_blue};
  end

  brs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- three-lane MAC
  // weights sum to 65536, so each lane stays below 2^24
  always_comb begin
    sum_r = acc_r + ACC_W'(ACC_W'(ram_rdata[2*CH_W +: CH_W]) * ACC_W'(wt));
    sum_g = acc_g + ACC_W'(ACC_W'(ram_rdata[CH_W +: CH_W]) * ACC_W'(wt));
    sum_b = acc_b + ACC_W'(ACC_W'(ram_rdata[0 +: CH_W]) * ACC_W'(wt));
  end

  always_ff @(posedge clk) begin
    if (state == ST_MY) begin
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else if (acc_en) begin
      acc_r <= sum_r;
      acc_g <= sum_g;
      acc_b <= sum_b;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (smp && smp_oor) begin
      red          <= '0;
      green        <= '0;
      blue         <= '0;
      out_of_range <= 1'b1;
    end else if (state == ST_FIN) begin
      red          <= sum_r[ACC_W-1 -: CH_W];
      green        <= sum_g[ACC_W-1 -: CH_W];
      blue         <= sum_b[ACC_W-1 -: CH_W];
      out_of_range <= 1'b0;
    end
  end

endmodule

// ===== design/brs_ram.sv =====
// brs_ram: generic single-port RAM, one write or one read a cycle, registered read.
// No dependencies.
`timescale 1ns / 1ps

module brs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/brs_div.sv =====
// brs_div: restoring divider, one quotient bit per cycle.
// No dependencies; used by the scaler top level for the Q16 steps.
`timescale 1ns / 1ps

module brs_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem, q[NUM_W-1]};
    diff  = trial - {1'b0, dsr};
    ge    = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of q as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dsr <= den;
    end else if (run) begin
      q   <= {q[NUM_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quot = q;

endmodule

// ===== design/brs_checker.sv =====
// brs_checker: port-level checks on the scaler, bound to every bilinear_rgb_scaler.
// Depends on brs_pkg.
`timescale 1ns / 1ps

module brs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           kind,
  input logic                           done,
  input logic [brs_pkg::CH_W-1:0]       red,
  input logic [brs_pkg::CH_W-1:0]       green,
  input logic [brs_pkg::CH_W-1:0]       blue,
  input logic                           out_of_range,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  import brs_pkg::*;

  // a result always leaves with the block free for the next beat
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // flagged samples carry black
  a_oor_black: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (red == '0 && green == '0 && blue == '0))
    else $error("out-of-range result with non-zero colour");

  // a load beat gives no result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_LOAD) |=> !done)
    else $error("result after a load beat");

  // busy only rises after a sample beat or a config beat
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past((start && kind == KIND_SAMPLE) || (cfg_valid && cfg_ready)))
    else $error("busy rose without a sample or config beat");

endmodule

bind bilinear_rgb_scaler brs_checker u_brs_checker (.*);

// ===== sim/bilinear_rgb_scaler_tb.sv =====
`timescale 1ns / 1ps
// bilinear_rgb_scaler_tb: self-checking bench for the bilinear RGB scaler.
// Depends on brs_pkg and the scaler RTL. Holds a queued driver, a bit-true colour
// predictor and a strobe monitor.

module bilinear_rgb_scaler_tb;
  import brs_pkg::*;

  // must match the instance parameters below
  localparam int MAX_SRC_W = 256;
  localparam int MAX_SRC_H = 256;
  localparam int MAX_DST_W = 1024;
  localparam int MAX_DST_H = 600;

  localparam int ITEM_TARGET    = 1900;
  localparam int SETTLE_CYCLES  = 12;    // quiet cycles before a register write or pause ends
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat at all

  // index that decodes to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_PAUSE} action_e;

  // one queued beat: an item, a register write or a wait for the results to drain
  typedef struct packed {
    action_e                act;
    logic                   kind;
    logic [COORD_W-1:0]     x;
    logic [COORD_W-1:0]     y;
    logic [CH_W-1:0]        r;
    logic [CH_W-1:0]        g;
    logic [CH_W-1:0]        b;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [2:0]             gap;   // idle cycles before start is raised
  } beat_t;

  typedef struct packed {
    logic [SW_W-1:0] src_w;
    logic [SH_W-1:0] src_h;
    logic [TW_W-1:0] dst_w;
    logic [TH_W-1:0] dst_h;
  } geometry_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            oor;
  } colour_t;

  localparam geometry_t GEO_RESET = '{src_w: 9'd256, src_h: 9'd256,
                                      dst_w: 11'd1024, dst_h: 10'd600};

  // DUT ports; the inputs are all known from time zero
  logic                   clk;
  logic                   rst         = 1'b1;
  logic                   start       = 1'b0;
  logic                   busy;
  logic                   kind        = KIND_LOAD;
  logic [COORD_W-1:0]     x_pos       = '0;
  logic [COORD_W-1:0]     y_pos       = '0;
  logic [CH_W-1:0]        pixel_red   = '0;
  logic [CH_W-1:0]        pixel_green = '0;
  logic [CH_W-1:0]        pixel_blue  = '0;
  logic                   done;
  logic [CH_W-1:0]        red;
  logic [CH_W-1:0]        green;
  logic [CH_W-1:0]        blue;
  logic                   out_of_range;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;

  // stimulus plan and the expected colours
  beat_t     pending_beats [$];
  colour_t   pending_colours [$];

  // planning side: geometry as it will be when the beat is reached, pixels loaded so far
  geometry_t plan_geo = GEO_RESET;
  bit        loaded_map [0:MAX_SRC_W*MAX_SRC_H-1];
  bit        gaps_on = 1'b1;
  int        planned_items = 0;

  // predictor side: copy of the registers and the pixel store
  geometry_t cfg_now = GEO_RESET;
  pixel_t    source_image [0:MAX_SRC_W*MAX_SRC_H-1];

  // driver state
  beat_t     drive = '0;
  bit        head_seen = 1'b0;
  int        gap_left = 0;
  int        settle = 0;
  int        stall_cycles = 0;

  int errors = 0;
  int n_loads = 0, n_ignored = 0, n_samples = 0, n_oor = 0, n_cfg = 0, n_results = 0;

  bilinear_rgb_scaler #(
    .MAX_SRC_WIDTH (MAX_SRC_W),
    .MAX_SRC_HEIGHT(MAX_SRC_H),
    .MAX_DST_WIDTH (MAX_DST_W),
    .MAX_DST_HEIGHT(MAX_DST_H)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .done        (done),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .out_of_range(out_of_range),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------------------
  // Register semantics: the write is cut to the register width, then 0 becomes 1 and
  // anything above the maximum becomes the maximum. Unknown indexes are dropped.
  // ---------------------------------------------------------------------------------------
  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] raw,
                                            input int unsigned keep, input int unsigned hi);
    int unsigned v;
    v = raw & ((32'd1 << keep) - 32'd1);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic geometry_t write_register(input geometry_t g,
                                               input logic [CFG_IDX_W-1:0] idx,
                                               input logic [CFG_DATA_W-1:0] data);
    geometry_t n;
    n = g;
    case (idx)
      REG_SRC_WIDTH:  n.src_w = SW_W'(clamp_dim(data, SW_W, MAX_SRC_W));
      REG_SRC_HEIGHT: n.src_h = SH_W'(clamp_dim(data, SH_W, MAX_SRC_H));
      REG_TGT_WIDTH:  n.dst_w = TW_W'(clamp_dim(data, TW_W, MAX_DST_W));
      REG_TGT_HEIGHT: n.dst_h = TH_W'(clamp_dim(data, TH_W, MAX_DST_H));
      default: ;
    endcase
    return n;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Colour predictor. Q16 step = ((src-1) << 16) / dst, position = coord * step,
  // weight = bits 15:8 of the position, right/lower neighbour clamps at the last
  // column/row, each channel is the weighted sum >> 16, truncated.
  // ---------------------------------------------------------------------------------------
  function automatic colour_t interpolate_pixel(input logic [COORD_W-1:0] xp,
                                                input logic [COORD_W-1:0] yp);
    step_t             x_step, y_step;
    logic [PROD_W-1:0] x_q, y_q;
    int unsigned       x1, y1, x2, y2, wx, wy, acc;
    pixel_t            p11, p12, p21, p22;
    logic [CH_W-1:0]   chan [3];
    int                c;
    colour_t           res;
    res = '0;
    if (xp >= cfg_now.dst_w || yp >= cfg_now.dst_h) begin
      // outside the target: flag with black
      res.oor = 1'b1;
      return res;
    end
    x_step = step_t'(((32'(cfg_now.src_w) - 32'd1) << FRAC_W) / cfg_now.dst_w);
    y_step = step_t'(((32'(cfg_now.src_h) - 32'd1) << FRAC_W) / cfg_now.dst_h);
    x_q = PROD_W'(xp) * PROD_W'(x_step);
    y_q = PROD_W'(yp) * PROD_W'(y_step);
    x1 = 32'(x_q >> FRAC_W);
    y1 = 32'(y_q >> FRAC_W);
    wx = 32'(x_q[FRAC_W-1 -: WFRAC_W]);
    wy = 32'(y_q[FRAC_W-1 -: WFRAC_W]);
    // a one-pixel source has step 0, so both neighbours are the same column/row
    x2 = (x1 < 32'(cfg_now.src_w) - 32'd1) ? x1 + 1 : x1;
    y2 = (y1 < 32'(cfg_now.src_h) - 32'd1) ? y1 + 1 : y1;
    p11 = source_image[y1 * MAX_SRC_W + x1];
    p12 = source_image[y1 * MAX_SRC_W + x2];
    p21 = source_image[y2 * MAX_SRC_W + x1];
    p22 = source_image[y2 * MAX_SRC_W + x2];
    for (c = 0; c < 3; c++) begin
      acc = 32'(p11[PIX_W-1-CH_W*c -: CH_W]) * (32'd256 - wx) * (32'd256 - wy)
          + 32'(p12[PIX_W-1-CH_W*c -: CH_W]) * wx * (32'd256 - wy)
          + 32'(p21[PIX_W-1-CH_W*c -: CH_W]) * (32'd256 - wx) * wy
          + 32'(p22[PIX_W-1-CH_W*c -: CH_W]) * wx * wy;
      chan[c] = CH_W'(acc >> FRAC_W);
    end
    res.red   = chan[0];
    res.green = chan[1];
    res.blue  = chan[2];
    return res;
  endfunction

  // predictor update for one accepted item beat
  task automatic absorb_item(input beat_t b);
    if (b.kind == KIND_LOAD) begin
      n_loads++;
      if (b.x < cfg_now.src_w && b.y < cfg_now.src_h)
        source_image[b.y * MAX_SRC_W + b.x] = {b.r, b.g, b.b};
      else
        n_ignored++;  // outside the source, dropped by the block
    end else begin
      n_samples++;
      pending_colours.push_back(interpolate_pixel(b.x, b.y));
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Planning helpers, run at time zero. They track the geometry each beat will meet so
  // that no in-range sample can ever touch a pixel that was not loaded.
  // ---------------------------------------------------------------------------------------
  task automatic queue_item(input logic k, input int unsigned x, input int unsigned y,
                            input pixel_t colour);
    beat_t b;
    bit    inside_src;
    b = '0;
    b.act  = ACT_ITEM;
    b.kind = k;
    b.x    = COORD_W'(x);
    b.y    = COORD_W'(y);
    {b.r, b.g, b.b} = colour;
    b.gap  = (gaps_on && $urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 6)) : 3'd0;
    pending_beats.push_back(b);
    inside_src = (x < plan_geo.src_w) && (y < plan_geo.src_h);
    if (k == KIND_LOAD && inside_src) loaded_map[y * MAX_SRC_W + x] = 1'b1;
    planned_items++;
  endtask

  task automatic queue_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned raw);
    beat_t b;
    b = '0;
    b.act  = ACT_CFG;
    b.idx  = idx;
    b.data = CFG_DATA_W'(raw);
    pending_beats.push_back(b);
    plan_geo = write_register(plan_geo, idx, b.data);
  endtask

  task automatic queue_pause();
    beat_t b;
    b = '0;
    b.act = ACT_PAUSE;
    pending_beats.push_back(b);
  endtask

  // write all four registers, then load every source pixel not yet loaded
  task automatic set_geometry(input int unsigned sw, input int unsigned sh,
                              input int unsigned tw, input int unsigned th);
    int unsigned xi, yi;
    queue_cfg(REG_SRC_WIDTH, sw);
    queue_cfg(REG_SRC_HEIGHT, sh);
    queue_cfg(REG_TGT_WIDTH, tw);
    queue_cfg(REG_TGT_HEIGHT, th);
    for (yi = 0; yi < plan_geo.src_h; yi++)
      for (xi = 0; xi < plan_geo.src_w; xi++)
        if (!loaded_map[yi * MAX_SRC_W + xi])
          queue_item(KIND_LOAD, xi, yi, PIX_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------------------
  initial begin
    int pick, body, r, phase, sw, sh, tw, th;
    int unsigned x, y;

    // directed: out-of-range samples and loads under the reset geometry
    queue_item(KIND_SAMPLE, 0, 600, '0);            // first row below the target
    queue_item(KIND_SAMPLE, 1023, 1023, PIX_W'(-1)); // coordinate extremes
    queue_item(KIND_LOAD, 300, 5, PIX_W'(-1));       // column beyond the source
    queue_item(KIND_LOAD, 5, 700, '0);               // row beyond the source
    queue_cfg(REG_UNUSED, $urandom_range(0, 2047));  // no register behind it

    // zero writes clamp to one: single-pixel source, single-pixel target
    set_geometry(0, 0, 0, 0);
    queue_item(KIND_LOAD, 0, 0, 24'hFFFFFF);
    queue_item(KIND_SAMPLE, 0, 0, '0);
    queue_item(KIND_SAMPLE, 1, 0, '0);
    queue_item(KIND_SAMPLE, 0, 1, '0);

    // 2x2 source upscaled to 3x3, corners at the channel extremes
    set_geometry(2, 2, 3, 3);
    queue_item(KIND_LOAD, 0, 0, 24'hFFFFFF);
    queue_item(KIND_LOAD, 1, 0, 24'h000000);
    queue_item(KIND_LOAD, 0, 1, 24'h00FF00);
    queue_item(KIND_LOAD, 1, 1, 24'hFF00FF);
    queue_item(KIND_SAMPLE, 0, 0, '0);
    queue_item(KIND_SAMPLE, 1, 1, '0);
    queue_item(KIND_SAMPLE, 2, 2, '0);   // last target column and row
    queue_item(KIND_SAMPLE, 2, 1, '0);
    queue_item(KIND_LOAD, 2, 0, 24'h123456);  // dropped: column 2 not in a 2-wide source

    // downscale in x, upscale in y
    set_geometry(3, 2, 2, 5);
    queue_item(KIND_SAMPLE, 1, 4, '0);
    queue_item(KIND_SAMPLE, 1, 0, '0);
    queue_item(KIND_SAMPLE, 2, 4, '0);
    queue_pause();

    // random phases, each with its own geometry
    phase = 0;
    while (planned_items < ITEM_TARGET) begin
      gaps_on = (phase % 5 != 2) && (planned_items < ITEM_TARGET - 250);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        set_geometry(511, 1, 2047, 0);     // clamps to 256 x 1 -> 1024 x 1
      end else if (pick == 1) begin
        set_geometry(0, 300, 1, 1023);     // clamps to 1 x 256 -> 1 x 600
      end else begin
        sw = $urandom_range(1, 12);
        sh = $urandom_range(1, 12);
        tw = $urandom_range(1, 48);
        th = $urandom_range(1, 48);
        if ($urandom_range(0, 5) == 0) tw = $urandom_range(1024, 2047);
        if ($urandom_range(0, 5) == 0) th = $urandom_range(600, 1023);
        // bits above the register width are dropped by the block
        if ($urandom_range(0, 7) == 0) sw += $urandom_range(1, 3) << 9;
        if ($urandom_range(0, 7) == 0) sh += $urandom_range(1, 3) << 9;
        if ($urandom_range(0, 7) == 0) th += 1024;
        set_geometry(sw, sh, tw, th);
      end
      body = $urandom_range(30, 90);
      repeat (body) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          queue_item(KIND_SAMPLE, $urandom_range(0, plan_geo.dst_w - 1),
                     $urandom_range(0, plan_geo.dst_h - 1), PIX_W'($urandom));
        end else if (r < 72) begin
          if (plan_geo.dst_w < 1024 && $urandom_range(0, 1) == 0) begin
            x = $urandom_range(plan_geo.dst_w, 1023);
            y = $urandom_range(0, 1023);
          end else begin
            x = $urandom_range(0, 1023);
            y = $urandom_range(plan_geo.dst_h, 1023);
          end
          queue_item(KIND_SAMPLE, x, y, PIX_W'($urandom));
        end else if (r < 92) begin
          queue_item(KIND_LOAD, $urandom_range(0, plan_geo.src_w - 1),
                     $urandom_range(0, plan_geo.src_h - 1), PIX_W'($urandom));
        end else begin
          if ($urandom_range(0, 1) == 0) begin
            x = $urandom_range(plan_geo.src_w, 1023);
            y = $urandom_range(0, 1023);
          end else begin
            x = $urandom_range(0, 1023);
            y = $urandom_range(plan_geo.src_h, 1023);
          end
          queue_item(KIND_LOAD, x, y, PIX_W'($urandom));
        end
        if (gaps_on && $urandom_range(0, 39) == 0) queue_pause();
      end
      phase++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    while (pending_colours.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_colours.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pending_colours.size());
      errors++;
    end

    $display("ran %0d phases: %0d loads (%0d dropped), %0d samples (%0d flagged outside)",
             phase, n_loads, n_ignored, n_samples, n_oor);
    $display("%0d register writes, %0d results checked, %0d errors",
             n_cfg, n_results, errors);
    if (errors == 0) begin
      $display("bilinear_rgb_scaler_tb OK");
    end else begin
      $display("bilinear_rgb_scaler_tb NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Driver. Item beat on start & !busy, register beat on cfg_valid & cfg_ready. Register
  // writes and pauses wait for all colours to arrive plus a quiet spell, as a load gives
  // no strobe to wait on. Out of reset each input gets exactly one nonblocking write per edge.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : drive_beats
    beat_t head;
    logic  n_start, n_cfg_valid;
    if (rst) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      cfg_now   = GEO_RESET;
      head_seen = 1'b0;
      settle    = 0;
    end else begin
      n_start     = start;
      n_cfg_valid = cfg_valid;
      if ((start && !busy) || (cfg_valid && cfg_ready) || done)
        settle = 0;
      else if (settle < SETTLE_CYCLES)
        settle++;

      if (start && !busy) begin
        absorb_item(pending_beats[0]);
        void'(pending_beats.pop_front());
        n_start   = 1'b0;
        head_seen = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        cfg_now = write_register(cfg_now, cfg_index, cfg_data);
        n_cfg++;
        void'(pending_beats.pop_front());
        n_cfg_valid = 1'b0;
        head_seen   = 1'b0;
      end

      // next beat, unless one is still on offer
      if (!n_start && !n_cfg_valid && pending_beats.size() != 0) begin
        head = pending_beats[0];
        case (head.act)
          ACT_ITEM: begin
            if (!head_seen) begin
              gap_left  = head.gap;
              head_seen = 1'b1;
            end
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              drive   = head;
              n_start = 1'b1;
            end
          end
          ACT_CFG: begin
            if (pending_colours.size() == 0 && settle >= SETTLE_CYCLES && !busy) begin
              drive       = head;
              n_cfg_valid = 1'b1;
            end
          end
          ACT_PAUSE: begin
            // sender holds off until the block has nothing in flight
            if (pending_colours.size() == 0 && settle >= SETTLE_CYCLES)
              void'(pending_beats.pop_front());
          end
          default: ;
        endcase
      end

      start       <= n_start;
      cfg_valid   <= n_cfg_valid;
      kind        <= drive.kind;
      x_pos       <= drive.x;
      y_pos       <= drive.y;
      pixel_red   <= drive.r;
      pixel_green <= drive.g;
      pixel_blue  <= drive.b;
      cfg_index   <= drive.idx;
      cfg_data    <= drive.data;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: every done strobe is one result beat, matched against the oldest colour.
  // ---------------------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [CH_W-1:0] want,
                             input logic [CH_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    colour_t want;
    if (!rst && done) begin
      if (pending_colours.size() == 0) begin
        $display("%0t ns: unexpected result beat, got %0d/%0d/%0d out_of_range %0d",
                 $time, red, green, blue, out_of_range);
        errors++;
      end else begin
        want = pending_colours.pop_front();
        n_results++;
        if (want.oor) n_oor++;
        check_field("red", want.red, red);
        check_field("green", want.green, green);
        check_field("blue", want.blue, blue);
        check_field("out_of_range", CH_W'(want.oor), CH_W'(out_of_range));
      end
    end
  end

  // watchdog: any beat on any channel restarts the count
  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles, %0d beats and %0d results outstanding",
               $time, stall_cycles, pending_beats.size(), pending_colours.size());
      $display("bilinear_rgb_scaler_tb NOT OK");
      $finish;
    end
  end

endmodule
